>>> sv/rtdf_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rtdf_pkg: shared definitions for the rotate and trial division factor unit
// Field widths, result limits and the divider status bundle.
// ---------------------------------------------------------------------------
package rtdf_pkg;

  localparam int WIDTH_DEFAULT = 32;
  localparam int VALUE_W       = 32;
  localparam int AMOUNT_W      = 5;
  localparam int FACTOR_W      = 32;
  localparam int MAX_RESULTS   = 31;
  localparam int FIRST_DIVISOR = 2;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

>>> sv/rtdf_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rtdf_div: iterative restoring divider
// Produces one quotient bit per cycle; quotient and remainder hold until the
// next start.
// ---------------------------------------------------------------------------
module rtdf_div import rtdf_pkg::*; #(
  parameter int WIDTH = WIDTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic [WIDTH-1:0] quotient,
  output logic [WIDTH-1:0] remainder,
  output div_status_t      status
);

  localparam int CW = $clog2(WIDTH);

  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] quo;
  logic [WIDTH-1:0] dsr;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic             done;
  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   trial;

  assign shifted = {acc, quo[WIDTH-1]};
  assign trial   = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !start && (cnt == '0);
      if (start) begin
        acc  <= '0;
        quo  <= dividend;
        dsr  <= divisor;
        cnt  <= CW'(WIDTH - 1);
        busy <= 1'b1;
      end else if (busy) begin
        // A clear top bit of the trial difference means the divisor fits.
        if (!trial[WIDTH]) begin
          acc <= trial[WIDTH-1:0];
          quo <= {quo[WIDTH-2:0], 1'b1};
        end else begin
          acc <= shifted[WIDTH-1:0];
          quo <= {quo[WIDTH-2:0], 1'b0};
        end
        if (cnt == '0) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  assign quotient    = quo;
  assign remainder   = acc;
  assign status.busy = busy;
  assign status.done = done;

endmodule

>>> sv/rotate_and_trial_division_factor_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rotate_and_trial_division_factor_unit: rotate a word and factor it
// Rotates the input right and emits its prime factors in ascending order.
// ---------------------------------------------------------------------------
// Usage: an input transfer (value, rotate_amount) rotates the low WIDTH bits
// of value right by rotate_amount modulo WIDTH and factors the result by
// trial division from 2 upward. Each prime factor leaves as one output
// transfer, repeated by multiplicity, and the final one has last set. A
// rotated value of 0 or 1 gives a single result with factor 0 and last set.
// Each divisor trial is one pass through the shared restoring divider, and
// a divisor that divides is then emitted. Trials run until the divisor
// squared exceeds the cofactor, so an item needs up to about 2^(WIDTH/2)
// trials, and a rotated value of 0 or 1 needs no trial at all.
// in_ready is high only while no item is being factored; the next item may
// be taken while the final result still waits in the output register.
// When the receiver stalls, the sequencer holds the pending factor and
// waits. Reset empties the output register and returns to idle.
// ---------------------------------------------------------------------------
module rotate_and_trial_division_factor_unit import rtdf_pkg::*; #(
  parameter int WIDTH = WIDTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [VALUE_W-1:0]  value,
  input  logic [AMOUNT_W-1:0] rotate_amount,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [FACTOR_W-1:0] factor,
  output logic                last
);

  localparam int EXT_W = (WIDTH > VALUE_W) ? WIDTH : VALUE_W;
  localparam int RW    = $clog2(WIDTH);
  localparam int NW    = $clog2(MAX_RESULTS);
  localparam logic [NW-1:0] N_LAST = NW'(MAX_RESULTS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_DECIDE,
    S_EMIT
  } state_t;

  state_t           state;
  logic [WIDTH-1:0] rem;
  logic [WIDTH-1:0] d;
  logic [NW-1:0]    n;
  logic [WIDTH-1:0] pend_factor;
  logic             pend_last;
  logic             div_start;
  logic             emit_now;

  logic [WIDTH-1:0] div_q;
  logic [WIDTH-1:0] div_r;
  div_status_t      div_stat;

  logic [EXT_W-1:0]   value_ext;
  logic [WIDTH-1:0]   value_w;
  logic [6:0]         amt_red;
  logic [RW-1:0]      rot;
  logic [2*WIDTH-1:0] rot_pair;
  logic [WIDTH-1:0]   rotated;
  logic [EXT_W-1:0]   pend_ext;

  // Reduce the rotate amount modulo WIDTH; four subtractions cover WIDTH >= 8.
  always_comb begin
    amt_red = 7'(rotate_amount);
    for (int i = 0; i < 4; i++) begin
      if (amt_red >= 7'(WIDTH)) begin
        amt_red = amt_red - 7'(WIDTH);
      end
    end
  end

  assign value_ext = EXT_W'(value);
  assign value_w   = value_ext[WIDTH-1:0];
  assign rot       = amt_red[RW-1:0];
  assign rot_pair  = {value_w, value_w} >> rot;
  assign rotated   = rot_pair[WIDTH-1:0];
  assign pend_ext  = EXT_W'(pend_factor);

  assign in_ready = (state == S_IDLE);

  // The output register takes a new factor when it is empty or being drained.
  assign emit_now = (state == S_EMIT) && (!out_valid || out_ready);

  rtdf_div #(
    .WIDTH(WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rem),
    .divisor  (d),
    .quotient (div_q),
    .remainder(div_r),
    .status   (div_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      div_start <= 1'b0;
    end else begin
      if (emit_now) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            rem   <= rotated;
            d     <= WIDTH'(FIRST_DIVISOR);
            n     <= '0;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (rem <= WIDTH'(1)) begin
            pend_factor <= '0;
            pend_last   <= 1'b1;
            state       <= S_EMIT;
          end else if (!div_stat.busy) begin
            div_start <= 1'b1;
            state     <= S_DIV;
          end
        end
        S_DIV: begin
          div_start <= 1'b0;
          if (div_stat.done) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (d > div_q) begin
            // No divisor up to the square root: the cofactor is prime.
            pend_factor <= rem;
            pend_last   <= 1'b1;
            state       <= S_EMIT;
          end else if (div_r == '0) begin
            rem         <= div_q;
            pend_factor <= d;
            pend_last   <= (div_q == WIDTH'(1)) || (n == N_LAST);
            n           <= n + 1'b1;
            state       <= S_EMIT;
          end else begin
            d     <= d + 1'b1;
            state <= S_CHECK;
          end
        end
        S_EMIT: begin
          if (emit_now) begin
            factor <= pend_ext[FACTOR_W-1:0];
            last   <= pend_last;
            state  <= pend_last ? S_IDLE : S_CHECK;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> sv/rtdf_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rtdf_checker: port-level checks for the factor unit
// Watches the top-level ports and flags sequencing slips.
// ---------------------------------------------------------------------------
module rtdf_checker import rtdf_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [FACTOR_W-1:0] factor,
  input logic                last
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(factor) && $stable(last))
    else $error("stalled result changed");

  // Once an item is taken, the unit is busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after an input transfer");

  // A result that is not the last means an item is still being factored.
  a_not_ready_mid_item: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> !in_ready)
    else $error("ready high while an item is unfinished");

  // The no-factor marker is always the final result.
  a_zero_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (factor == '0) |-> last)
    else $error("zero factor without last");

endmodule

bind rotate_and_trial_division_factor_unit rtdf_checker u_rtdf_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .factor   (factor),
  .last     (last)
);
